[rtl/core/ctk_pkg.sv]
// shared types, codes and character classes of the character stream tokenizer
package ctk_pkg;

  localparam int CH_W   = 8;
  localparam int KIND_W = 6;
  localparam int POS_W  = 16;
  localparam int COL_W  = 12;
  localparam int MODE_W = 3;
  localparam int MAX_TOK = 3;

  // scanner modes
  localparam logic [MODE_W-1:0] MODE_IDLE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INT   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DOT   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FLOAT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WORD  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_OP    = 3'd5;

  // token kinds
  localparam logic [KIND_W-1:0] K_END     = 6'd0;
  localparam logic [KIND_W-1:0] K_INT     = 6'd1;
  localparam logic [KIND_W-1:0] K_FLOAT   = 6'd2;
  localparam logic [KIND_W-1:0] K_WORD    = 6'd3;
  localparam logic [KIND_W-1:0] K_PLUS    = 6'd4;
  localparam logic [KIND_W-1:0] K_MINUS   = 6'd6;
  localparam logic [KIND_W-1:0] K_STAR    = 6'd8;
  localparam logic [KIND_W-1:0] K_SLASH   = 6'd10;
  localparam logic [KIND_W-1:0] K_LPAREN  = 6'd12;
  localparam logic [KIND_W-1:0] K_RPAREN  = 6'd13;
  localparam logic [KIND_W-1:0] K_SEMI    = 6'd14;
  localparam logic [KIND_W-1:0] K_ASSIGN  = 6'd15;
  localparam logic [KIND_W-1:0] K_LBRACE  = 6'd17;
  localparam logic [KIND_W-1:0] K_RBRACE  = 6'd18;
  localparam logic [KIND_W-1:0] K_NOTEQ   = 6'd19;
  localparam logic [KIND_W-1:0] K_LT      = 6'd20;
  localparam logic [KIND_W-1:0] K_GT      = 6'd22;
  localparam logic [KIND_W-1:0] K_CARET   = 6'd24;
  localparam logic [KIND_W-1:0] K_AMP     = 6'd26;
  localparam logic [KIND_W-1:0] K_PIPE    = 6'd28;
  localparam logic [KIND_W-1:0] K_TILDE   = 6'd30;
  localparam logic [KIND_W-1:0] K_ILLEGAL = 6'd32;
  localparam logic [KIND_W-1:0] K_NONE    = 6'd0;

  // characters
  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_BANG  = 8'h21;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [CH_W-1:0] CH_US    = 8'h5F;

  typedef struct packed {
    logic [KIND_W-1:0] token_kind;
    logic [POS_W-1:0]  start_pos;
    logic [POS_W-1:0]  token_len;
    logic [POS_W-1:0]  start_line;
    logic [COL_W-1:0]  start_col;
    logic              last;
  } tok_t;

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [CH_W-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_wordch(input logic [CH_W-1:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_US);
  endfunction

  // one-character kind of an operator that may take a trailing '='
  function automatic logic [KIND_W-1:0] op_base(input logic [CH_W-1:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      8'h2B:   k = K_PLUS;
      8'h2D:   k = K_MINUS;
      8'h2A:   k = K_STAR;
      8'h2F:   k = K_SLASH;
      CH_EQ:   k = K_ASSIGN;
      8'h3C:   k = K_LT;
      8'h3E:   k = K_GT;
      8'h5E:   k = K_CARET;
      8'h26:   k = K_AMP;
      8'h7C:   k = K_PIPE;
      8'h7E:   k = K_TILDE;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  // kind of an operator that never takes '='
  function automatic logic [KIND_W-1:0] op_single(input logic [CH_W-1:0] c);
    logic [KIND_W-1:0] k;
    unique case (c)
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h3B:   k = K_SEMI;
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      default: k = K_NONE;
    endcase
    return k;
  endfunction

endpackage

[rtl/core/ctk_stream_if.sv]
// valid/ready channel interfaces for source bytes and tokens
interface ctk_in_if;
  logic                      valid;
  logic                      ready;
  logic [ctk_pkg::CH_W-1:0]  ch;
  logic                      end_of_input;

  modport source (output valid, ch, end_of_input, input ready);
  modport sink   (input valid, ch, end_of_input, output ready);
endinterface

interface ctk_tok_if;
  logic                        valid;
  logic                        ready;
  logic [ctk_pkg::KIND_W-1:0]  token_kind;
  logic [ctk_pkg::POS_W-1:0]   start_pos;
  logic [ctk_pkg::POS_W-1:0]   token_len;
  logic [ctk_pkg::POS_W-1:0]   start_line;
  logic [ctk_pkg::COL_W-1:0]   start_col;
  logic                        last;

  modport source (output valid, token_kind, start_pos, token_len, start_line, start_col,
                  last, input ready);
  modport sink   (input valid, token_kind, start_pos, token_len, start_line, start_col,
                  last, output ready);
endinterface

[rtl/core/ctk_scan.sv]
// per-byte scanner step: next state and up to three tokens
module ctk_scan #(
  parameter int POS_BITS = 16,
  parameter int COL_BITS = 12
) (
  input  logic [ctk_pkg::CH_W-1:0]    ch,
  input  logic                        end_of_input,
  input  logic [ctk_pkg::MODE_W-1:0]  mode,
  input  logic [ctk_pkg::CH_W-1:0]    pend,
  input  logic [POS_BITS-1:0]         tok_start,
  input  logic [POS_BITS-1:0]         tok_line,
  input  logic [COL_BITS-1:0]         tok_col,
  input  logic [POS_BITS-1:0]         cur_pos,
  input  logic [POS_BITS-1:0]         cur_line,
  input  logic [COL_BITS-1:0]         cur_col,
  output logic [ctk_pkg::MODE_W-1:0]  mode_next,
  output logic [ctk_pkg::CH_W-1:0]    pend_next,
  output logic [POS_BITS-1:0]         tok_start_next,
  output logic [POS_BITS-1:0]         tok_line_next,
  output logic [COL_BITS-1:0]         tok_col_next,
  output logic [POS_BITS-1:0]         cur_pos_next,
  output logic [POS_BITS-1:0]         cur_line_next,
  output logic [COL_BITS-1:0]         cur_col_next,
  output ctk_pkg::tok_t [ctk_pkg::MAX_TOK-1:0] toks,
  output logic [1:0]                  tok_cnt
);

  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [COL_BITS-1:0] COL_MAX = '1;

  function automatic ctk_pkg::tok_t mk(input logic [ctk_pkg::KIND_W-1:0] kind,
                                       input logic [POS_BITS-1:0] pos,
                                       input logic [POS_BITS-1:0] len,
                                       input logic [POS_BITS-1:0] line,
                                       input logic [COL_BITS-1:0] col);
    ctk_pkg::tok_t t;
    t.token_kind = kind;
    t.start_pos  = ctk_pkg::POS_W'(pos);
    t.token_len  = ctk_pkg::POS_W'(len);
    t.start_line = ctk_pkg::POS_W'(line);
    t.start_col  = ctk_pkg::COL_W'(col);
    t.last       = 1'b0;
    return t;
  endfunction

  logic                        eoi;
  logic                        used;
  logic                        adv;
  logic                        mark;
  logic [POS_BITS-1:0]         dpos;
  logic [COL_BITS-1:0]         dcol;
  logic [POS_BITS-1:0]         ilen;
  logic [ctk_pkg::KIND_W-1:0]  base;
  logic [ctk_pkg::KIND_W-1:0]  one_k;
  logic [ctk_pkg::KIND_W-1:0]  two_k;
  logic [ctk_pkg::KIND_W-1:0]  single_k;
  logic                        is_ws;

  assign eoi      = end_of_input || (ch == ctk_pkg::CH_NUL);
  assign base     = ctk_pkg::op_base(pend);
  assign single_k = ctk_pkg::op_single(ch);
  assign is_ws    = (ch == ctk_pkg::CH_SPACE) || (ch == ctk_pkg::CH_TAB) ||
                    (ch == ctk_pkg::CH_NL);
  assign dpos     = (cur_pos != '0) ? cur_pos - 1'b1 : '0;
  assign dcol     = (cur_col != '0) ? cur_col - 1'b1 : '0;
  assign ilen     = (dpos >= tok_start) ? dpos - tok_start : '0;
  assign one_k    = (pend == ctk_pkg::CH_BANG) ? ctk_pkg::K_ILLEGAL :
                    (base != ctk_pkg::K_NONE) ? base : ctk_pkg::K_ILLEGAL;
  assign two_k    = (pend == ctk_pkg::CH_BANG) ? ctk_pkg::K_NOTEQ :
                    (base != ctk_pkg::K_NONE) ? base + 1'b1 : ctk_pkg::K_ILLEGAL;

  always_comb begin
    mode_next = mode;
    pend_next = pend;
    used      = 1'b0;
    adv       = 1'b0;
    mark      = 1'b0;
    tok_cnt   = 2'd0;
    toks      = '0;

    unique case (mode)
      ctk_pkg::MODE_INT: begin
        if (!eoi && ctk_pkg::is_digit(ch)) begin
          adv  = 1'b1;
          used = 1'b1;
        end else if (!eoi && ch == ctk_pkg::CH_DOT) begin
          adv       = 1'b1;
          used      = 1'b1;
          mode_next = ctk_pkg::MODE_DOT;
        end else begin
          toks[tok_cnt] = mk(ctk_pkg::K_INT, tok_start, cur_pos - tok_start, tok_line,
                             tok_col);
          tok_cnt   = tok_cnt + 2'd1;
          mode_next = ctk_pkg::MODE_IDLE;
        end
      end
      ctk_pkg::MODE_DOT: begin
        if (!eoi && ctk_pkg::is_digit(ch)) begin
          adv       = 1'b1;
          used      = 1'b1;
          mode_next = ctk_pkg::MODE_FLOAT;
        end else begin
          // dangling dot: integer, then the dot as an illegal token
          toks[tok_cnt] = mk(ctk_pkg::K_INT, tok_start, ilen, tok_line, tok_col);
          tok_cnt       = tok_cnt + 2'd1;
          toks[tok_cnt] = mk(ctk_pkg::K_ILLEGAL, dpos, POS_BITS'(1), cur_line, dcol);
          tok_cnt       = tok_cnt + 2'd1;
          mode_next     = ctk_pkg::MODE_IDLE;
        end
      end
      ctk_pkg::MODE_FLOAT, ctk_pkg::MODE_WORD: begin
        if (!eoi && ((mode == ctk_pkg::MODE_FLOAT) ? ctk_pkg::is_digit(ch)
                                                   : ctk_pkg::is_wordch(ch))) begin
          adv  = 1'b1;
          used = 1'b1;
        end else begin
          toks[tok_cnt] = mk((mode == ctk_pkg::MODE_FLOAT) ? ctk_pkg::K_FLOAT
                                                            : ctk_pkg::K_WORD,
                             tok_start, cur_pos - tok_start, tok_line, tok_col);
          tok_cnt   = tok_cnt + 2'd1;
          mode_next = ctk_pkg::MODE_IDLE;
        end
      end
      ctk_pkg::MODE_OP: begin
        if (!eoi && ch == ctk_pkg::CH_EQ) begin
          toks[tok_cnt] = mk(two_k, tok_start, POS_BITS'(2), tok_line, tok_col);
          tok_cnt = tok_cnt + 2'd1;
          adv     = 1'b1;
          used    = 1'b1;
        end else begin
          toks[tok_cnt] = mk(one_k, tok_start, POS_BITS'(1), tok_line, tok_col);
          tok_cnt = tok_cnt + 2'd1;
        end
        mode_next = ctk_pkg::MODE_IDLE;
        pend_next = '0;
      end
      default: mode_next = ctk_pkg::MODE_IDLE;
    endcase

    if (!used) begin
      priority if (eoi) begin
        toks[tok_cnt] = mk(ctk_pkg::K_END, cur_pos, '0, cur_line, cur_col);
        tok_cnt   = tok_cnt + 2'd1;
        mode_next = ctk_pkg::MODE_IDLE;
      end else if (is_ws) begin
        adv = 1'b1;
      end else if (ctk_pkg::is_digit(ch)) begin
        mark      = 1'b1;
        mode_next = ctk_pkg::MODE_INT;
        adv       = 1'b1;
      end else if (ctk_pkg::is_alpha(ch) || ch == ctk_pkg::CH_US) begin
        mark      = 1'b1;
        mode_next = ctk_pkg::MODE_WORD;
        adv       = 1'b1;
      end else if (ctk_pkg::op_base(ch) != ctk_pkg::K_NONE || ch == ctk_pkg::CH_BANG) begin
        mark      = 1'b1;
        mode_next = ctk_pkg::MODE_OP;
        pend_next = ch;
        adv       = 1'b1;
      end else begin
        toks[tok_cnt] = mk((single_k != ctk_pkg::K_NONE) ? single_k : ctk_pkg::K_ILLEGAL,
                           cur_pos, POS_BITS'(1), cur_line, cur_col);
        tok_cnt = tok_cnt + 2'd1;
        adv     = 1'b1;
      end
    end

    for (int i = 0; i < ctk_pkg::MAX_TOK; i++) begin
      toks[i].last = (tok_cnt != 2'd0) && (2'(i) == tok_cnt - 2'd1);
    end
  end

  // token start is taken before the byte advances the counters
  always_comb begin
    tok_start_next = mark ? cur_pos  : tok_start;
    tok_line_next  = mark ? cur_line : tok_line;
    tok_col_next   = mark ? cur_col  : tok_col;
    cur_pos_next   = cur_pos;
    cur_line_next  = cur_line;
    cur_col_next   = cur_col;
    if (adv) begin
      if (cur_pos != POS_MAX) cur_pos_next = cur_pos + 1'b1;
      if (ch == ctk_pkg::CH_NL) begin
        if (cur_line != POS_MAX) cur_line_next = cur_line + 1'b1;
        cur_col_next = '0;
      end else if (cur_col != COL_MAX) begin
        cur_col_next = cur_col + 1'b1;
      end
    end
  end

endmodule

[rtl/core/char_stream_tokenizer.sv]
// character stream tokenizer top level: scanner state and token output buffer
//
//   channel  modport           payload
//   src      ctk_in_if.sink    ch, end_of_input
//   tok      ctk_tok_if.source token_kind, start_pos, token_len, start_line, start_col, last
//
// one source byte per cycle while tok accepts: each transaction is scanned in the cycle it is
// taken and its zero to three tokens land in a three-entry output buffer.
// a byte that yields at most one token keeps one byte per cycle; a byte that yields more
// tokens holds src.ready low while the buffer drains, until one entry remains and it is leaving.
// synchronous reset clears the scanner to idle at line 1, column 0, position 0.
// a stall on tok holds the buffer; src is taken again once one entry at most remains
// and it is leaving.
module char_stream_tokenizer #(
  parameter int POS_BITS = 16,
  parameter int COL_BITS = 12
) (
  input  logic       clk,
  input  logic       rst,
  ctk_in_if.sink     src,
  ctk_tok_if.source  tok
);

  logic [ctk_pkg::MODE_W-1:0]  mode;
  logic [ctk_pkg::CH_W-1:0]    pend;
  logic [POS_BITS-1:0]         tok_start;
  logic [POS_BITS-1:0]         tok_line;
  logic [COL_BITS-1:0]         tok_col;
  logic [POS_BITS-1:0]         cur_pos;
  logic [POS_BITS-1:0]         cur_line;
  logic [COL_BITS-1:0]         cur_col;

  logic [ctk_pkg::MODE_W-1:0]  mode_next;
  logic [ctk_pkg::CH_W-1:0]    pend_next;
  logic [POS_BITS-1:0]         tok_start_next;
  logic [POS_BITS-1:0]         tok_line_next;
  logic [COL_BITS-1:0]         tok_col_next;
  logic [POS_BITS-1:0]         cur_pos_next;
  logic [POS_BITS-1:0]         cur_line_next;
  logic [COL_BITS-1:0]         cur_col_next;

  ctk_pkg::tok_t [ctk_pkg::MAX_TOK-1:0] new_toks;
  logic [1:0]                           new_cnt;

  ctk_pkg::tok_t [ctk_pkg::MAX_TOK-1:0] slots;
  logic [1:0]                           cnt;

  logic take;
  logic pop;

  ctk_scan #(
    .POS_BITS (POS_BITS),
    .COL_BITS (COL_BITS)
  ) u_scan (
    .ch             (src.ch),
    .end_of_input   (src.end_of_input),
    .mode           (mode),
    .pend           (pend),
    .tok_start      (tok_start),
    .tok_line       (tok_line),
    .tok_col        (tok_col),
    .cur_pos        (cur_pos),
    .cur_line       (cur_line),
    .cur_col        (cur_col),
    .mode_next      (mode_next),
    .pend_next      (pend_next),
    .tok_start_next (tok_start_next),
    .tok_line_next  (tok_line_next),
    .tok_col_next   (tok_col_next),
    .cur_pos_next   (cur_pos_next),
    .cur_line_next  (cur_line_next),
    .cur_col_next   (cur_col_next),
    .toks           (new_toks),
    .tok_cnt        (new_cnt)
  );

  assign pop       = tok.valid && tok.ready;
  assign src.ready = (cnt == 2'd0) || ((cnt == 2'd1) && tok.ready);
  assign take      = src.valid && src.ready;

  assign tok.valid      = (cnt != 2'd0);
  assign tok.token_kind = slots[0].token_kind;
  assign tok.start_pos  = slots[0].start_pos;
  assign tok.token_len  = slots[0].token_len;
  assign tok.start_line = slots[0].start_line;
  assign tok.start_col  = slots[0].start_col;
  assign tok.last       = slots[0].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= ctk_pkg::MODE_IDLE;
      pend      <= '0;
      tok_start <= '0;
      tok_line  <= POS_BITS'(1);
      tok_col   <= '0;
      cur_pos   <= '0;
      cur_line  <= POS_BITS'(1);
      cur_col   <= '0;
    end else if (take) begin
      mode      <= mode_next;
      pend      <= pend_next;
      tok_start <= tok_start_next;
      tok_line  <= tok_line_next;
      tok_col   <= tok_col_next;
      cur_pos   <= cur_pos_next;
      cur_line  <= cur_line_next;
      cur_col   <= cur_col_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (take) begin
      cnt <= new_cnt;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // the buffer shifts toward entry zero as tokens leave
  always_ff @(posedge clk) begin
    if (take) begin
      slots <= new_toks;
    end else if (pop) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
    end
  end

endmodule
